// ----- hdl/jcd_pkg.sv -----
// jcd_pkg: shared types and constants of the joystick calibrate and direction block
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package jcd_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] OP_CENTRE  = 2'd0;
    localparam logic [1:0] OP_CALIB   = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;

    // direction codes
    localparam logic [2:0] DIR_NEUTRAL = 3'd0;
    localparam logic [2:0] DIR_LEFT    = 3'd1;
    localparam logic [2:0] DIR_UP      = 3'd2;
    localparam logic [2:0] DIR_RIGHT   = 3'd3;
    localparam logic [2:0] DIR_DOWN    = 3'd4;

    localparam int QUOT_BITS  = 7;
    localparam int POS_BITS   = 8;
    localparam int DIR_BITS   = 3;
    localparam int THR_BITS   = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [QUOT_BITS-1:0] SCALE_FULL      = 7'd100;
    localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 8'd80;
    localparam logic [2:0]           DIV_FIRST_SHIFT = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       prep;
        logic       check;
        logic       div_step;
        logic       store;
        logic       square;
        logic       finish;
        logic       axis_y;
        logic [2:0] shift;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/joystick_calibrate_and_direction.sv -----
// joystick_calibrate_and_direction: top level, stream ports around controller and datapath
// depends on jcd_pkg, jcd_controller, jcd_datapath
`timescale 1ns / 1ps

// Conditions a two-axis joystick. Each input request carries a kind on tuser: centre capture
// stores the rest position, a calibration sample widens the per-axis min and max (reset to
// all ones and zero), and a measure sample produces one result: each axis scaled around its
// centre to -100..100 with truncating division and saturation, the button state, a direction
// (neutral unless x^2 + y^2 exceeds the threshold squared, then left, up, right or down split
// at the diagonals) and a fault flag when a used span is zero or negative, in which case that
// axis reads 0. Centre and calibration requests give no result. A measure request runs, per
// axis, a prepare step (offset times 100), a saturation check, the seven steps of the shared
// restoring divider and a store, then a squaring step and a direction compare whose result
// is loaded into the output register; that load waits while the register holds an untaken
// result, and the input is ready again after it. The result sits in an output register, so
// a new request is accepted while it waits. The threshold register is written through the
// cfg port at any time (ready is always high) and resets to 80.

module joystick_calibrate_and_direction #(
    parameter int ADC_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // adc_x, adc_y, button_pressed, zero padding
    input  logic [((2*ADC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic [1:0]              s_axis_tuser,

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // pos_x, pos_y, pressed, direction, span_fault, zero padding
    output logic [jcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    // direction_threshold
    input  logic [jcd_pkg::THR_BITS-1:0] i_cfg_data
);

    localparam int OUT_USED = 2*jcd_pkg::POS_BITS + 1 + jcd_pkg::DIR_BITS + 1;

    jcd_pkg::t_dp_cmd    s_cmd;
    jcd_pkg::t_dp_status s_status;

    logic signed [jcd_pkg::POS_BITS-1:0] s_pos_x, s_pos_y;
    logic                                s_pressed, s_fault;
    logic [jcd_pkg::DIR_BITS-1:0]        s_dir;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    jcd_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_op      (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_status  (s_status),
        .o_cmd     (s_cmd)
    );

    jcd_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_status     (s_status),
        .i_op         (s_axis_tuser),
        .i_adc_x      (s_axis_tdata[ADC_BITS-1:0]),
        .i_adc_y      (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_button     (s_axis_tdata[2*ADC_BITS]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .o_pos_x      (s_pos_x),
        .o_pos_y      (s_pos_y),
        .o_pressed    (s_pressed),
        .o_direction  (s_dir),
        .o_span_fault (s_fault)
    );

    // pack result, lowest field first
    assign m_axis_tdata = {{(jcd_pkg::OUT_TDATA_W-OUT_USED){1'b0}},
                           s_fault, s_dir, s_pressed, s_pos_y, s_pos_x};

endmodule

// ----- hdl/jcd_datapath.sv -----
// jcd_datapath: calibration state, shared restoring divider, direction logic, output register
// depends on jcd_pkg; sequenced by jcd_controller
`timescale 1ns / 1ps

module jcd_datapath #(
    parameter int ADC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  jcd_pkg::t_dp_cmd                  i_cmd,
    output jcd_pkg::t_dp_status               o_status,
    input  logic [1:0]                        i_op,
    input  logic [ADC_BITS-1:0]               i_adc_x,
    input  logic [ADC_BITS-1:0]               i_adc_y,
    input  logic                              i_button,
    input  logic                              i_cfg_valid,
    input  logic [jcd_pkg::THR_BITS-1:0]      i_cfg_data,
    input  logic                              i_m_ready,
    output logic                              o_m_valid,
    output logic signed [jcd_pkg::POS_BITS-1:0] o_pos_x,
    output logic signed [jcd_pkg::POS_BITS-1:0] o_pos_y,
    output logic                              o_pressed,
    output logic [jcd_pkg::DIR_BITS-1:0]      o_direction,
    output logic                              o_span_fault
);

    localparam int NUM_W = ADC_BITS + jcd_pkg::QUOT_BITS;
    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    // calibration state
    logic [ADC_BITS-1:0] r_centre_x, r_centre_y, r_max_x, r_max_y, r_min_x, r_min_y;
    logic [jcd_pkg::THR_BITS-1:0] r_thr;

    // latched item
    logic [ADC_BITS-1:0] r_adc_x, r_adc_y;
    logic                r_btn;

    // divider
    logic [NUM_W-1:0]               r_num;
    logic [ADC_BITS-1:0]            r_span;
    logic [jcd_pkg::QUOT_BITS-1:0]  r_quot;
    logic                           r_neg, r_afault, r_sat, r_fault;

    logic signed [jcd_pkg::POS_BITS-1:0] r_pos_x, r_pos_y;
    logic [13:0] r_xx, r_yy;
    logic [15:0] r_tt;

    logic                                r_m_valid;
    logic signed [jcd_pkg::POS_BITS-1:0] r_o_pos_x, r_o_pos_y;
    logic                                r_o_pressed, r_o_fault;
    logic [jcd_pkg::DIR_BITS-1:0]        r_o_dir;

    // axis selection for the prepare step
    logic [ADC_BITS-1:0] s_v, s_c, s_hi, s_lo, s_mag;
    logic [ADC_BITS:0]   s_span;
    logic                s_above, s_span_bad;
    logic [NUM_W-1:0]    s_num, s_trial;

    always_comb begin
        s_v  = i_cmd.axis_y ? r_adc_y    : r_adc_x;
        s_c  = i_cmd.axis_y ? r_centre_y : r_centre_x;
        s_hi = i_cmd.axis_y ? r_max_y    : r_max_x;
        s_lo = i_cmd.axis_y ? r_min_y    : r_min_x;
        s_above = s_v > s_c;
        if (s_above) begin
            s_span = {1'b0, s_hi} - {1'b0, s_c};
            s_mag  = s_v - s_c;
        end else begin
            s_span = {1'b0, s_c} - {1'b0, s_lo};
            s_mag  = s_c - s_v;
        end
        // negative or zero span
        s_span_bad = s_span[ADC_BITS] || (s_span == '0);
        s_num   = NUM_W'(s_mag) * NUM_W'(jcd_pkg::SCALE_FULL);
        s_trial = NUM_W'(r_span) << i_cmd.shift;
    end

    // saturated, signed axis value
    logic [jcd_pkg::QUOT_BITS-1:0]       s_qmag;
    logic signed [jcd_pkg::POS_BITS-1:0] s_axis_val;

    always_comb begin
        s_qmag = (r_sat || (r_quot > jcd_pkg::SCALE_FULL)) ? jcd_pkg::SCALE_FULL : r_quot;
        if (r_afault) begin
            s_axis_val = '0;
        end else if (r_neg) begin
            s_axis_val = -$signed({1'b0, s_qmag});
        end else begin
            s_axis_val = $signed({1'b0, s_qmag});
        end
    end

    // direction sectors
    logic signed [15:0] s_sq_x, s_sq_y;
    logic [14:0]        s_sum;
    logic signed [jcd_pkg::POS_BITS:0] s_x, s_y, s_nx;
    logic [jcd_pkg::DIR_BITS-1:0] s_dir;

    always_comb begin
        s_sq_x = 16'(r_pos_x) * 16'(r_pos_x);
        s_sq_y = 16'(r_pos_y) * 16'(r_pos_y);
        s_sum  = {1'b0, r_xx} + {1'b0, r_yy};
        s_x    = {r_pos_x[jcd_pkg::POS_BITS-1], r_pos_x};
        s_y    = {r_pos_y[jcd_pkg::POS_BITS-1], r_pos_y};
        s_nx   = -s_x;
        if ({1'b0, s_sum} <= r_tt) begin
            s_dir = jcd_pkg::DIR_NEUTRAL;
        end else if (s_y > 0 && s_y > s_x && s_y >= s_nx) begin
            s_dir = jcd_pkg::DIR_UP;
        end else if (s_x > 0 && s_y <= s_x && s_y > s_nx) begin
            s_dir = jcd_pkg::DIR_RIGHT;
        end else if (s_y < 0 && s_y <= s_nx && s_y < s_x) begin
            s_dir = jcd_pkg::DIR_DOWN;
        end else begin
            s_dir = jcd_pkg::DIR_LEFT;
        end
    end

    // calibration state and threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_max_x    <= '0;
            r_max_y    <= '0;
            r_min_x    <= ADC_MAX;
            r_min_y    <= ADC_MAX;
            r_thr      <= jcd_pkg::THRESHOLD_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.load && i_op == jcd_pkg::OP_CENTRE) begin
                r_centre_x <= i_adc_x;
                r_centre_y <= i_adc_y;
            end
            if (i_cmd.load && i_op == jcd_pkg::OP_CALIB) begin
                if (i_adc_x > r_max_x) r_max_x <= i_adc_x;
                if (i_adc_y > r_max_y) r_max_y <= i_adc_y;
                if (i_adc_x < r_min_x) r_min_x <= i_adc_x;
                if (i_adc_y < r_min_y) r_min_y <= i_adc_y;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_adc_x <= i_adc_x;
            r_adc_y <= i_adc_y;
            r_btn   <= i_button;
            r_fault <= 1'b0;
        end
        if (i_cmd.prep) begin
            r_num    <= s_num;
            r_span   <= s_span[ADC_BITS-1:0];
            r_neg    <= !s_above && (s_v != s_c);
            r_afault <= s_span_bad;
            r_quot   <= '0;
            if (s_span_bad) r_fault <= 1'b1;
        end
        if (i_cmd.check) begin
            r_sat <= r_num >= {r_span, {jcd_pkg::QUOT_BITS{1'b0}}};
        end
        if (i_cmd.div_step && r_num >= s_trial) begin
            r_num                 <= r_num - s_trial;
            r_quot[i_cmd.shift]   <= 1'b1;
        end
        if (i_cmd.store) begin
            if (i_cmd.axis_y) r_pos_y <= s_axis_val;
            else              r_pos_x <= s_axis_val;
        end
        if (i_cmd.square) begin
            r_xx <= s_sq_x[13:0];
            r_yy <= s_sq_y[13:0];
            r_tt <= 16'(r_thr) * 16'(r_thr);
        end
        if (i_cmd.finish) begin
            r_o_pos_x   <= r_pos_x;
            r_o_pos_y   <= r_pos_y;
            r_o_pressed <= r_btn;
            r_o_dir     <= s_dir;
            r_o_fault   <= r_fault;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_m_valid || i_m_ready;
    assign o_m_valid    = r_m_valid;
    assign o_pos_x      = r_o_pos_x;
    assign o_pos_y      = r_o_pos_y;
    assign o_pressed    = r_o_pressed;
    assign o_direction  = r_o_dir;
    assign o_span_fault = r_o_fault;

endmodule

// ----- hdl/jcd_controller.sv -----
// jcd_controller: sequencer for one measure request through both axes and the direction step
// depends on jcd_pkg; drives jcd_datapath
`timescale 1ns / 1ps

module jcd_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic [1:0]          i_op,
    output logic                o_s_ready,
    input  jcd_pkg::t_dp_status i_status,
    output jcd_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_STORE  = 3'd4;
    localparam logic [2:0] ST_SQUARE = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_axis_y, n_axis_y;
    logic       s_accept;

    assign o_s_ready = (r_state == ST_IDLE) && i_rst_n;
    assign s_accept  = o_s_ready && i_s_valid;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_axis_y = r_axis_y;
        o_cmd    = '0;
        o_cmd.axis_y = r_axis_y;
        o_cmd.shift  = r_step;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = s_accept;
                n_axis_y   = 1'b0;
                if (s_accept && i_op == jcd_pkg::OP_MEASURE) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_step      = jcd_pkg::DIV_FIRST_SHIFT;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_STORE;
                end else begin
                    n_step = r_step - 3'd1;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                if (r_axis_y) begin
                    n_state = ST_SQUARE;
                end else begin
                    n_axis_y = 1'b1;
                    n_state  = ST_PREP;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_axis_y <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_axis_y <= n_axis_y;
        end
    end

endmodule

// ----- hdl/jcd_checker.sv -----
// jcd_checker: port-level assertions for joystick_calibrate_and_direction, with its bind
// depends on the top level's port list only
`timescale 1ns / 1ps

module jcd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a measure request occupies the block
    a_measure_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == 2'd2 |=> !s_axis_tready)
        else $error("request taken during measure");

    // centre, calibration and unused requests leave the input ready
    a_update_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != 2'd2 |=> s_axis_tready)
        else $error("update request stalled the input");

    // scaled positions stay in range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) >= -8'sd100)
                       && ($signed(m_axis_tdata[7:0]) <= 8'sd100)
                       && ($signed(m_axis_tdata[15:8]) >= -8'sd100)
                       && ($signed(m_axis_tdata[15:8]) <= 8'sd100))
        else $error("position out of range");

    // a direction needs a deflection
    a_dir_needs_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[19:17] != 3'd0 |-> m_axis_tdata[15:0] != 16'd0)
        else $error("direction without deflection");

endmodule

bind joystick_calibrate_and_direction jcd_checker u_jcd_checker (.*);

// ----- dv/joystick_calibrate_and_direction_tb.sv -----
// joystick_calibrate_and_direction_tb: self-checking bench for the joystick conditioning block
// depends on jcd_pkg and joystick_calibrate_and_direction; predicts every measure result
`timescale 1ns / 1ps

module joystick_calibrate_and_direction_tb;

    // the one op code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int FULL_DEFLECTION = 100;
    localparam int ITEM_TARGET = 900;
    // leave margin for a measure in flight before touching the register
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic              pressed;
        logic [2:0]        dir;
        logic              fault;
    } t_joy_reading;

    // tracks calibration state and holds the readings still owed by the block
    class t_joystick_checker;
        int threshold;
        int centre_x, centre_y;
        int max_x, min_x, max_y, min_y;
        t_joy_reading awaited[$];
        int errors;
        int checked;
        int dir_seen[5];

        function new();
            threshold = jcd_pkg::THRESHOLD_RESET;
            centre_x = 0;
            centre_y = 0;
            max_x = 0;
            max_y = 0;
            min_x = 255;
            min_y = 255;
            errors = 0;
            checked = 0;
            foreach (dir_seen[i]) dir_seen[i] = 0;
        endfunction

        function void set_threshold(logic [7:0] t);
            threshold = int'(t);
        endfunction

        // piecewise scaling around the centre, truncating division, saturated
        function int deflect(input int v, input int c, input int hi, input int lo,
                             inout bit fault);
            int span;
            int q;
            if (v > c) span = hi - c;
            else span = c - lo;
            if (span <= 0) begin
                fault = 1'b1;
                return 0;
            end
            q = ((v - c) * FULL_DEFLECTION) / span;
            if (q > FULL_DEFLECTION) q = FULL_DEFLECTION;
            if (q < -FULL_DEFLECTION) q = -FULL_DEFLECTION;
            return q;
        endfunction

        // sector split at the diagonals, boundary angles fall to the next sector clockwise
        function logic [2:0] heading(input int x, input int y);
            if (x * x + y * y <= threshold * threshold) return jcd_pkg::DIR_NEUTRAL;
            if (y > 0 && y > x && y >= -x) return jcd_pkg::DIR_UP;
            if (x > 0 && y <= x && y > -x) return jcd_pkg::DIR_RIGHT;
            if (y < 0 && y <= -x && y < x) return jcd_pkg::DIR_DOWN;
            return jcd_pkg::DIR_LEFT;
        endfunction

        function void take_sample(logic [1:0] op, logic [7:0] ax, logic [7:0] ay, logic btn);
            t_joy_reading r;
            bit fault;
            int px;
            int py;
            fault = 1'b0;
            case (op)
                jcd_pkg::OP_CENTRE: begin
                    centre_x = int'(ax);
                    centre_y = int'(ay);
                end
                jcd_pkg::OP_CALIB: begin
                    if (int'(ax) > max_x) max_x = int'(ax);
                    if (int'(ay) > max_y) max_y = int'(ay);
                    if (int'(ax) < min_x) min_x = int'(ax);
                    if (int'(ay) < min_y) min_y = int'(ay);
                end
                jcd_pkg::OP_MEASURE: begin
                    px = deflect(int'(ax), centre_x, max_x, min_x, fault);
                    py = deflect(int'(ay), centre_y, max_y, min_y, fault);
                    r.pos_x = px[7:0];
                    r.pos_y = py[7:0];
                    r.pressed = btn;
                    r.dir = heading(px, py);
                    r.fault = fault;
                    awaited.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_report(logic [jcd_pkg::OUT_TDATA_W-1:0] word);
            t_joy_reading want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result %h with no measure request pending", word));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.dir <= jcd_pkg::DIR_DOWN) dir_seen[want.dir]++;
            if (word[7:0] !== want.pos_x)
                report_mismatch($sformatf("pos_x %0d, want %0d",
                                          $signed(word[7:0]), want.pos_x));
            if (word[15:8] !== want.pos_y)
                report_mismatch($sformatf("pos_y %0d, want %0d",
                                          $signed(word[15:8]), want.pos_y));
            if (word[16] !== want.pressed)
                report_mismatch($sformatf("pressed %b, want %b", word[16], want.pressed));
            if (word[19:17] !== want.dir)
                report_mismatch($sformatf("direction %0d, want %0d", word[19:17], want.dir));
            if (word[20] !== want.fault)
                report_mismatch($sformatf("span_fault %b, want %b", word[20], want.fault));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // adc_x, adc_y, button_pressed, zero padding
    logic [23:0] s_axis_tdata = '0;
    // op
    logic [1:0]  s_axis_tuser = jcd_pkg::OP_CENTRE;

    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // pos_x, pos_y, pressed, direction, span_fault, zero padding
    logic [jcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    // direction_threshold
    logic [jcd_pkg::THR_BITS-1:0]  i_cfg_data = '0;

    t_joystick_checker sb = new();

    // idling switches per phase and the receiver's long hold-off request
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int hold_len = 0;

    int items_sent = 0;
    int centre_count = 0;
    int calib_count = 0;
    int thr_writes = 0;

    joystick_calibrate_and_direction dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one input request; valid stays high afterwards so back-to-back requests never
    // lower and raise it in the same step
    task automatic send_item(input logic [1:0] op, input logic [7:0] ax,
                             input logic [7:0] ay, input logic btn);
        int gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, btn, ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_sample(op, ax, ay, btn);
        if (op == jcd_pkg::OP_CENTRE) centre_count++;
        if (op == jcd_pkg::OP_CALIB) calib_count++;
        if (op != OP_UNUSED) items_sent++;
    endtask

    // stop offering, drain every owed result, then let a measure in flight finish
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_threshold(value);
        thr_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // reading with extra weight on the rails
    function automatic logic [7:0] pick_adc();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // calibration sample within a window around the centre
    function automatic logic [7:0] near(input int c, input int radius);
        int lo;
        int hi;
        lo = (c - radius < 0) ? 0 : c - radius;
        hi = (c + radius > 255) ? 255 : c + radius;
        return 8'($urandom_range(hi, lo));
    endfunction

    // receiver: random stalls per result, honors a long hold-off when one is requested
    initial begin
        int stall;
        forever begin
            if (hold_len > 0) begin
                stall = hold_len;
                hold_len = 0;
            end else begin
                stall = recv_idle ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_report(m_axis_tdata);
        end
    end

    // main sequence
    initial begin
        int phase;
        int n_calib;
        int radius;
        int cx;
        int cy;
        int pick;
        logic [7:0] thr;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: faults before calibration, saturation on narrow spans,
        // diagonals, threshold edge, ignored op code
        send_item(jcd_pkg::OP_MEASURE, 8'd255, 8'd0, 1'b1);
        send_item(OP_UNUSED, 8'h5A, 8'hA5, 1'b1);
        send_item(jcd_pkg::OP_MEASURE, 8'd0, 8'd255, 1'b0);
        send_item(jcd_pkg::OP_CENTRE, 8'd100, 8'd100, 1'b0);
        send_item(jcd_pkg::OP_CALIB, 8'd150, 8'd60, 1'b1);
        send_item(jcd_pkg::OP_MEASURE, 8'd200, 8'd50, 1'b1);   // both axes saturate
        send_item(jcd_pkg::OP_MEASURE, 8'd50, 8'd150, 1'b0);   // negative spans
        send_item(jcd_pkg::OP_MEASURE, 8'd150, 8'd60, 1'b1);
        send_item(jcd_pkg::OP_CALIB, 8'd0, 8'd0, 1'b0);
        send_item(jcd_pkg::OP_CALIB, 8'd255, 8'd255, 1'b1);
        send_item(jcd_pkg::OP_CENTRE, 8'd128, 8'd128, 1'b1);
        send_item(jcd_pkg::OP_MEASURE, 8'd255, 8'd255, 1'b1);  // diagonal, upper right
        send_item(jcd_pkg::OP_MEASURE, 8'd0, 8'd0, 1'b0);      // diagonal, lower left
        send_item(jcd_pkg::OP_MEASURE, 8'd255, 8'd0, 1'b1);    // diagonal, lower right
        send_item(jcd_pkg::OP_MEASURE, 8'd0, 8'd255, 1'b0);    // diagonal, upper left
        send_item(jcd_pkg::OP_MEASURE, 8'd230, 8'd128, 1'b1);  // magnitude equals threshold
        send_item(jcd_pkg::OP_MEASURE, 8'd231, 8'd128, 1'b0);  // just past threshold
        send_item(jcd_pkg::OP_MEASURE, 8'd128, 8'd128, 1'b1);
        send_item(jcd_pkg::OP_MEASURE, 8'd128, 8'd28, 1'b0);
        send_item(jcd_pkg::OP_MEASURE, 8'd128, 8'd20, 1'b1);
        send_item(jcd_pkg::OP_MEASURE, 8'd20, 8'd128, 1'b0);
        send_item(jcd_pkg::OP_CENTRE, 8'd0, 8'd255, 1'b0);     // centre on the rails
        send_item(jcd_pkg::OP_MEASURE, 8'd0, 8'd255, 1'b1);    // zero span on x
        send_item(jcd_pkg::OP_MEASURE, 8'd255, 8'd0, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);

        // random phases, each under its own threshold and idling mode
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            case (phase)
                0: thr = 8'd0;
                1: thr = 8'd141;
                2: thr = 8'd255;
                3: thr = jcd_pkg::THRESHOLD_RESET;
                4: thr = 8'd1;
                default: thr = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(142, 255))
                                                           : 8'($urandom_range(0, 141));
            endcase
            write_threshold(thr);

            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (phase == 1) begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end

            case ($urandom_range(0, 9))
                0: cx = 0;
                1: cx = 255;
                default: cx = $urandom_range(40, 215);
            endcase
            case ($urandom_range(0, 9))
                0: cy = 0;
                1: cy = 255;
                default: cy = $urandom_range(40, 215);
            endcase
            send_item(jcd_pkg::OP_CENTRE, 8'(cx), 8'(cy), 1'($urandom_range(0, 1)));

            // calibration window widens slowly so early spans stay narrow
            radius = (phase * 10 + 15 > 255) ? 255 : phase * 10 + 15;
            n_calib = $urandom_range(1, 4);
            repeat (n_calib)
                send_item(jcd_pkg::OP_CALIB, near(cx, radius), near(cy, radius),
                          1'($urandom_range(0, 1)));

            if (phase == 3) begin
                // receiver holds off while the sender keeps pushing measures
                send_idle = 1'b0;
                hold_len = 300;
                repeat (16)
                    send_item(jcd_pkg::OP_MEASURE, pick_adc(), pick_adc(),
                              1'($urandom_range(0, 1)));
            end else begin
                repeat (40) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                        send_item(jcd_pkg::OP_MEASURE, pick_adc(), pick_adc(),
                                  1'($urandom_range(0, 1)));
                    else if (pick < 85)
                        send_item(jcd_pkg::OP_MEASURE, 8'(cx), pick_adc(),
                                  1'($urandom_range(0, 1)));
                    else if (pick < 90)
                        send_item(jcd_pkg::OP_CENTRE, pick_adc(), pick_adc(),
                                  1'($urandom_range(0, 1)));
                    else if (pick < 95)
                        send_item(jcd_pkg::OP_CALIB, near(cx, radius), near(cy, radius),
                                  1'($urandom_range(0, 1)));
                    else
                        send_item(OP_UNUSED, pick_adc(), pick_adc(),
                                  1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end

        settle();
        if (sb.awaited.size() != 0)
            sb.report_mismatch($sformatf("%0d measure results never arrived",
                                         sb.awaited.size()));

        $display("checked %0d measure results over %0d phases, %0d centre and %0d calibration",
                 sb.checked, phase, centre_count, calib_count);
        $display("threshold written %0d times; neutral %0d left %0d up %0d right %0d down %0d",
                 thr_writes, sb.dir_seen[0], sb.dir_seen[1], sb.dir_seen[2],
                 sb.dir_seen[3], sb.dir_seen[4]);
        if (sb.errors == 0) begin
            $display("[joystick_calibrate_and_direction] OK");
        end else begin
            $display("[joystick_calibrate_and_direction] ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[joystick_calibrate_and_direction] ERROR");
        $finish;
    end

endmodule
